### sv/cbez_pkg.sv
`timescale 1ns / 1ps

package cbez_pkg;

    // Coordinates and points
    localparam int COORD_W    = 32;
    localparam int NUM_AXES   = 3;
    localparam int NUM_CP     = 4;
    localparam int NUM_COORDS = NUM_AXES * NUM_CP;

    // Point count register
    localparam int PPC_W      = 7;
    localparam int PPC_RESET  = 30;
    localparam int MIN_POINTS = 2;
    localparam int MAX_POINTS = 64;
    localparam int IDX_W      = $clog2(MAX_POINTS);

    // Parameter t, Q1.16 so that t = 1 is exact
    localparam int T_FRAC    = 16;
    localparam int T_W       = T_FRAC + 1;
    localparam int T_ONE_INT = 1 << T_FRAC;
    localparam logic [T_W-1:0] T_ONE = {1'b1, {T_FRAC{1'b0}}};
    localparam int T2_W      = 2 * T_W - 1;

    // Bernstein weights: exact in 2^-48, rounded to 2^-30
    localparam int RAW_W     = T2_W + T_W;
    localparam int RND_W     = RAW_W + 2;
    localparam int RAW_SHIFT = 3 * T_FRAC - 30;
    localparam int WGT_FRAC  = 30;
    localparam int W_W       = WGT_FRAC + 1;
    localparam int WSUM_W    = W_W + 2;

    // Blend products and sums
    localparam int PROD_W    = 2 * COORD_W;
    localparam int SUM_RND_W = PROD_W - WGT_FRAC;

    // Queue between front and back
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        t_coord [NUM_COORDS-1:0] coords;
        logic   [IDX_W-1:0]      last_idx;
    } t_curve;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             last;
    } t_tag;

endpackage

### sv/cbez_in_if.sv
`timescale 1ns / 1ps

interface cbez_in_if;
    logic                   valid;
    logic                   ready;
    cbez_pkg::t_coord       start_x;
    cbez_pkg::t_coord       start_y;
    cbez_pkg::t_coord       start_z;
    cbez_pkg::t_coord       ctrl_a_x;
    cbez_pkg::t_coord       ctrl_a_y;
    cbez_pkg::t_coord       ctrl_a_z;
    cbez_pkg::t_coord       ctrl_b_x;
    cbez_pkg::t_coord       ctrl_b_y;
    cbez_pkg::t_coord       ctrl_b_z;
    cbez_pkg::t_coord       end_x;
    cbez_pkg::t_coord       end_y;
    cbez_pkg::t_coord       end_z;

    modport source (
        output valid, start_x, start_y, start_z, ctrl_a_x, ctrl_a_y, ctrl_a_z,
               ctrl_b_x, ctrl_b_y, ctrl_b_z, end_x, end_y, end_z,
        input  ready
    );

    modport sink (
        input  valid, start_x, start_y, start_z, ctrl_a_x, ctrl_a_y, ctrl_a_z,
               ctrl_b_x, ctrl_b_y, ctrl_b_z, end_x, end_y, end_z,
        output ready
    );
endinterface

### sv/cbez_out_if.sv
`timescale 1ns / 1ps

interface cbez_out_if;
    logic                          valid;
    logic                          ready;
    cbez_pkg::t_coord              point_x;
    cbez_pkg::t_coord              point_y;
    cbez_pkg::t_coord              point_z;
    logic [cbez_pkg::IDX_W-1:0]    point_index;
    logic                          last_point;

    modport source (
        output valid, point_x, point_y, point_z, point_index, last_point,
        input  ready
    );

    modport sink (
        input  valid, point_x, point_y, point_z, point_index, last_point,
        output ready
    );
endinterface

### sv/cbez_cfg_if.sv
`timescale 1ns / 1ps

interface cbez_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [cbez_pkg::PPC_W-1:0]    points_per_curve;

    modport source (
        output valid, points_per_curve,
        input  ready
    );

    modport sink (
        input  valid, points_per_curve,
        output ready
    );
endinterface

### sv/cbez_front.sv
`timescale 1ns / 1ps

module cbez_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    cbez_cfg_if.sink          i_cfg,
    cbez_in_if.sink           i_curve,
    output logic              o_push_valid,
    input  logic              i_push_ready,
    output cbez_pkg::t_curve  o_push_data
);

    logic [cbez_pkg::PPC_W-1:0] r_ppc;
    logic [cbez_pkg::PPC_W-1:0] w_points;
    logic [cbez_pkg::PPC_W-1:0] w_last_wide;

    // Point count register, always writable
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ppc <= cbez_pkg::PPC_W'(cbez_pkg::PPC_RESET);
        end else if (i_cfg.valid) begin
            r_ppc <= i_cfg.points_per_curve;
        end
    end

    // Clamp the count into the supported range and tag the curve with its last index
    always_comb begin
        if (r_ppc < cbez_pkg::PPC_W'(cbez_pkg::MIN_POINTS)) begin
            w_points = cbez_pkg::PPC_W'(cbez_pkg::MIN_POINTS);
        end else if (r_ppc > cbez_pkg::PPC_W'(cbez_pkg::MAX_POINTS)) begin
            w_points = cbez_pkg::PPC_W'(cbez_pkg::MAX_POINTS);
        end else begin
            w_points = r_ppc;
        end
        w_last_wide = w_points - cbez_pkg::PPC_W'(1);
    end

    assign o_push_valid  = i_curve.valid;
    assign i_curve.ready = i_push_ready;

    always_comb begin
        o_push_data.coords[0]  = i_curve.start_x;
        o_push_data.coords[1]  = i_curve.start_y;
        o_push_data.coords[2]  = i_curve.start_z;
        o_push_data.coords[3]  = i_curve.ctrl_a_x;
        o_push_data.coords[4]  = i_curve.ctrl_a_y;
        o_push_data.coords[5]  = i_curve.ctrl_a_z;
        o_push_data.coords[6]  = i_curve.ctrl_b_x;
        o_push_data.coords[7]  = i_curve.ctrl_b_y;
        o_push_data.coords[8]  = i_curve.ctrl_b_z;
        o_push_data.coords[9]  = i_curve.end_x;
        o_push_data.coords[10] = i_curve.end_y;
        o_push_data.coords[11] = i_curve.end_z;
        o_push_data.last_idx   = w_last_wide[cbez_pkg::IDX_W-1:0];
    end

endmodule

### sv/cbez_fifo.sv
`timescale 1ns / 1ps

module cbez_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_valid,
    output logic              o_push_ready,
    input  cbez_pkg::t_curve  i_push_data,
    output logic              o_pop_valid,
    input  logic              i_pop_ready,
    output cbez_pkg::t_curve  o_pop_data
);

    cbez_pkg::t_curve                r_mem [cbez_pkg::FIFO_DEPTH];
    logic [cbez_pkg::FIFO_AW-1:0]    r_wptr;
    logic [cbez_pkg::FIFO_AW-1:0]    r_rptr;
    logic [cbez_pkg::FIFO_AW:0]      r_count;
    logic                            w_push;
    logic                            w_pop;

    assign o_push_ready = (r_count != (cbez_pkg::FIFO_AW + 1)'(cbez_pkg::FIFO_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= r_wptr + cbez_pkg::FIFO_AW'(1);
            end
            if (w_pop) begin
                r_rptr <= r_rptr + cbez_pkg::FIFO_AW'(1);
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + (cbez_pkg::FIFO_AW + 1)'(1);
                2'b01:   r_count <= r_count - (cbez_pkg::FIFO_AW + 1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

endmodule

### sv/cbez_back.sv
`timescale 1ns / 1ps

module cbez_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_curve_valid,
    output logic              o_curve_ready,
    input  cbez_pkg::t_curve  i_curve,
    cbez_out_if.source        o_point
);

    localparam logic [cbez_pkg::RND_W-1:0] W_HALF =
        {{(cbez_pkg::RND_W - cbez_pkg::RAW_SHIFT){1'b0}}, 1'b1,
         {(cbez_pkg::RAW_SHIFT - 1){1'b0}}};
    localparam logic signed [cbez_pkg::PROD_W-1:0] SUM_HALF =
        {{(cbez_pkg::PROD_W - cbez_pkg::WGT_FRAC){1'b0}}, 1'b1,
         {(cbez_pkg::WGT_FRAC - 1){1'b0}}};
    localparam logic [cbez_pkg::WSUM_W-1:0] W_ONE =
        {{(cbez_pkg::WSUM_W - cbez_pkg::WGT_FRAC - 1){1'b0}}, 1'b1,
         {cbez_pkg::WGT_FRAC{1'b0}}};
    localparam logic [cbez_pkg::WSUM_W-1:0] W_SLACK = cbez_pkg::WSUM_W'(2);

    // Step table: 1/d in t units as quotient and remainder
    logic [cbez_pkg::T_W-1:0]   w_tab_q [cbez_pkg::MAX_POINTS];
    logic [cbez_pkg::IDX_W-1:0] w_tab_r [cbez_pkg::MAX_POINTS];

    assign w_tab_q[0] = '0;
    assign w_tab_r[0] = '0;
    for (genvar g = 1; g < cbez_pkg::MAX_POINTS; g++) begin : g_step
        localparam int STEP_Q = cbez_pkg::T_ONE_INT / g;
        localparam int STEP_R = cbez_pkg::T_ONE_INT % g;
        assign w_tab_q[g] = cbez_pkg::T_W'(STEP_Q);
        assign w_tab_r[g] = cbez_pkg::IDX_W'(STEP_R);
    end

    // Point generator
    logic                          r_busy;
    logic [cbez_pkg::IDX_W-1:0]    r_idx;
    logic [cbez_pkg::IDX_W-1:0]    r_d;
    logic [cbez_pkg::T_W-1:0]      r_q;
    logic [cbez_pkg::IDX_W-1:0]    r_r;
    logic [cbez_pkg::T_W-1:0]      r_step_q;
    logic [cbez_pkg::IDX_W-1:0]    r_step_r;
    cbez_pkg::t_coord              r_coords [cbez_pkg::NUM_COORDS];

    logic                          w_adv;
    logic                          w_start;
    logic                          w_emit;
    logic                          w_last;
    logic [cbez_pkg::IDX_W:0]      w_rsum;
    logic                          w_wrap;

    // Stage A: t, u and their squares
    logic                          rA_v;
    cbez_pkg::t_tag                rA_tag;
    logic [cbez_pkg::T_W-1:0]      rA_t;
    logic [cbez_pkg::T_W-1:0]      rA_u;
    logic [cbez_pkg::T2_W-1:0]     rA_t2;
    logic [cbez_pkg::T2_W-1:0]     rA_u2;
    logic [cbez_pkg::T_W-1:0]      w_u;

    // Stage B: exact cubic terms
    logic                          rB_v;
    cbez_pkg::t_tag                rB_tag;
    logic [cbez_pkg::RAW_W-1:0]    rB_raw [cbez_pkg::NUM_CP];

    // Stage C: rounded weights
    logic                          rC_v;
    cbez_pkg::t_tag                rC_tag;
    logic [cbez_pkg::W_W-1:0]      rC_w [cbez_pkg::NUM_CP];
    logic [cbez_pkg::RND_W-1:0]    w_rnd_w [cbez_pkg::NUM_CP];
    logic [cbez_pkg::WSUM_W-1:0]   w_wsum;

    // Stage D: weighted coordinates
    logic                            rD_v;
    cbez_pkg::t_tag                  rD_tag;
    logic signed [cbez_pkg::PROD_W-1:0] rD_p [cbez_pkg::NUM_AXES][cbez_pkg::NUM_CP];

    // Stage E: pair sums
    logic                            rE_v;
    cbez_pkg::t_tag                  rE_tag;
    logic signed [cbez_pkg::PROD_W-1:0] rE_lo [cbez_pkg::NUM_AXES];
    logic signed [cbez_pkg::PROD_W-1:0] rE_hi [cbez_pkg::NUM_AXES];

    // Output register
    logic                            r_out_valid;
    cbez_pkg::t_tag                  r_out_tag;
    cbez_pkg::t_coord                r_out_pt [cbez_pkg::NUM_AXES];
    cbez_pkg::t_coord                w_sat [cbez_pkg::NUM_AXES];

    // Whole pipeline holds while the output register is full and stalled
    assign w_adv = !r_out_valid || o_point.ready;

    // Reload only once no point of the previous curve still needs the coordinates
    assign w_start       = !r_busy && i_curve_valid && !rA_v && !rB_v && !rC_v;
    assign o_curve_ready = w_start;
    assign w_emit        = r_busy && w_adv;
    assign w_last        = (r_idx == r_d);
    assign w_rsum        = {1'b0, r_r} + {1'b0, r_step_r};
    assign w_wrap        = (w_rsum >= {1'b0, r_d});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_start) begin
            r_busy <= 1'b1;
        end else if (w_emit && w_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_idx    <= '0;
            r_d      <= i_curve.last_idx;
            r_q      <= '0;
            r_r      <= i_curve.last_idx >> 1;
            r_step_q <= w_tab_q[i_curve.last_idx];
            r_step_r <= w_tab_r[i_curve.last_idx];
            for (int k = 0; k < cbez_pkg::NUM_COORDS; k++) begin
                r_coords[k] <= i_curve.coords[k];
            end
        end else if (w_emit) begin
            r_idx <= r_idx + cbez_pkg::IDX_W'(1);
            if (w_wrap) begin
                r_r <= cbez_pkg::IDX_W'(w_rsum - {1'b0, r_d});
                r_q <= r_q + r_step_q + cbez_pkg::T_W'(1);
            end else begin
                r_r <= w_rsum[cbez_pkg::IDX_W-1:0];
                r_q <= r_q + r_step_q;
            end
        end
    end

    // Valid bits of every stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rA_v        <= 1'b0;
            rB_v        <= 1'b0;
            rC_v        <= 1'b0;
            rD_v        <= 1'b0;
            rE_v        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            rA_v        <= r_busy;
            rB_v        <= rA_v;
            rC_v        <= rB_v;
            rD_v        <= rC_v;
            rE_v        <= rD_v;
            r_out_valid <= rE_v;
        end
    end

    assign w_u = cbez_pkg::T_ONE - r_q;

    always_comb begin
        for (int k = 0; k < cbez_pkg::NUM_CP; k++) begin
            if (k == 1 || k == 2) begin
                w_rnd_w[k] = {rB_raw[k], 1'b0} + cbez_pkg::RND_W'(rB_raw[k]) + W_HALF;
            end else begin
                w_rnd_w[k] = cbez_pkg::RND_W'(rB_raw[k]) + W_HALF;
            end
        end
        w_wsum = cbez_pkg::WSUM_W'(rC_w[0]) + cbez_pkg::WSUM_W'(rC_w[1])
               + cbez_pkg::WSUM_W'(rC_w[2]) + cbez_pkg::WSUM_W'(rC_w[3]);
    end

    // Round half up and saturate each axis
    always_comb begin
        logic signed [cbez_pkg::PROD_W-1:0]    tot;
        logic signed [cbez_pkg::SUM_RND_W-1:0] rnd;
        logic [cbez_pkg::SUM_RND_W-cbez_pkg::COORD_W:0] top;
        for (int a = 0; a < cbez_pkg::NUM_AXES; a++) begin
            tot = rE_lo[a] + rE_hi[a] + SUM_HALF;
            rnd = tot[cbez_pkg::PROD_W-1:cbez_pkg::WGT_FRAC];
            top = rnd[cbez_pkg::SUM_RND_W-1:cbez_pkg::COORD_W-1];
            if ((&top) || !(|top)) begin
                w_sat[a] = rnd[cbez_pkg::COORD_W-1:0];
            end else if (rnd[cbez_pkg::SUM_RND_W-1]) begin
                w_sat[a] = {1'b1, {(cbez_pkg::COORD_W - 1){1'b0}}};
            end else begin
                w_sat[a] = {1'b0, {(cbez_pkg::COORD_W - 1){1'b1}}};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            // A
            rA_tag.idx  <= r_idx;
            rA_tag.last <= w_last;
            rA_t        <= r_q;
            rA_u        <= w_u;
            rA_t2       <= r_q * r_q;
            rA_u2       <= w_u * w_u;
            // B
            rB_tag    <= rA_tag;
            rB_raw[0] <= rA_u2 * rA_u;
            rB_raw[1] <= rA_u2 * rA_t;
            rB_raw[2] <= rA_t2 * rA_u;
            rB_raw[3] <= rA_t2 * rA_t;
            // C
            rC_tag <= rB_tag;
            for (int k = 0; k < cbez_pkg::NUM_CP; k++) begin
                rC_w[k] <= w_rnd_w[k][cbez_pkg::RAW_SHIFT +: cbez_pkg::W_W];
            end
            // D
            rD_tag <= rC_tag;
            for (int a = 0; a < cbez_pkg::NUM_AXES; a++) begin
                for (int k = 0; k < cbez_pkg::NUM_CP; k++) begin
                    rD_p[a][k] <= r_coords[k * cbez_pkg::NUM_AXES + a]
                                * $signed({1'b0, rC_w[k]});
                end
            end
            // E
            rE_tag <= rD_tag;
            for (int a = 0; a < cbez_pkg::NUM_AXES; a++) begin
                rE_lo[a] <= rD_p[a][0] + rD_p[a][1];
                rE_hi[a] <= rD_p[a][2] + rD_p[a][3];
            end
            // Output
            r_out_tag <= rE_tag;
            for (int a = 0; a < cbez_pkg::NUM_AXES; a++) begin
                r_out_pt[a] <= w_sat[a];
            end
        end
    end

    assign o_point.valid       = r_out_valid;
    assign o_point.point_x     = r_out_pt[0];
    assign o_point.point_y     = r_out_pt[1];
    assign o_point.point_z     = r_out_pt[2];
    assign o_point.point_index = r_out_tag.idx;
    assign o_point.last_point  = r_out_tag.last;

    // Stepping remainder stays below the divisor
    ap_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_r < r_d))
        else $error("t step remainder out of range");

    ap_first_t: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_idx == '0) |-> (r_q == '0))
        else $error("first point of a curve not at t = 0");

    ap_last_t: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && w_last) |-> (r_q == cbez_pkg::T_ONE))
        else $error("last point of a curve not at t = 1");

    ap_wsum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rC_v |-> ((w_wsum >= W_ONE - W_SLACK) && (w_wsum <= W_ONE + W_SLACK)))
        else $error("rounded weights do not sum to one");

    ap_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_curve_valid && o_curve_ready) |=> (r_busy && r_idx == '0))
        else $error("curve taken without restarting the generator");

endmodule

### sv/cubic_bezier_tessellator_core.sv
`timescale 1ns / 1ps

// Channel    Modport   Moves                                   Handshake
// i_cfg      sink      points_per_curve (clamped to 2..64)      valid/ready, ready always high
// i_curve    sink      one request: P0, P1, P2, P3, Q24.8 xyz   valid/ready
// o_point    source    point_x/y/z, point_index, last_point     valid/ready
//
// One request gives n points (n = clamped points_per_curve), one per cycle while
// o_point is not stalled. The generator takes a new curve only once the last one is done,
// and its coordinate registers reload only once the weight stages have drained.
// A taken curve's first point passes stages A to E and then the output register.
// A two-entry queue holds waiting curves; a stalled output freezes the back end's stages.
// Reset is synchronous, active low; points_per_curve returns to 30, queue empties.

module cubic_bezier_tessellator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cbez_cfg_if.sink    i_cfg,
    cbez_in_if.sink     i_curve,
    cbez_out_if.source  o_point
);

    // Front to queue
    logic             w_push_valid;
    logic             w_push_ready;
    cbez_pkg::t_curve w_push_data;

    // Queue to back
    logic             w_pop_valid;
    logic             w_pop_ready;
    cbez_pkg::t_curve w_pop_data;

    // Hold the point count, clamp it and tag each request with its last index
    cbez_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (i_cfg),
        .i_curve      (i_curve),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_push_data  (w_push_data)
    );

    // Decouple intake from evaluation
    cbez_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_data  (w_push_data),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_data   (w_pop_data)
    );

    // Step t, form the Bernstein weights, blend, round and saturate
    cbez_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_curve_valid (w_pop_valid),
        .o_curve_ready (w_pop_ready),
        .i_curve       (w_pop_data),
        .o_point       (o_point)
    );

endmodule
